### src/esc_pkg.sv
// ============================================================================
// esc_pkg: shared types and constants for the epoch seconds converter
// Field widths, reciprocal constants and the start-of-year day function.
// ============================================================================
package esc_pkg;

    typedef logic [31:0] t_epoch;
    typedef logic [7:0]  t_year;
    typedef logic [8:0]  t_doy;
    typedef logic [4:0]  t_hour;
    typedef logic [5:0]  t_min;
    typedef logic [5:0]  t_sec;
    typedef logic [15:0] t_days;
    typedef logic [16:0] t_secs_of_day;
    typedef logic [11:0] t_secs_of_hour;

    // 86400 = 2^7 * 675: seconds are shifted by 7 before dividing by 675
    localparam int unsigned DAY_SHIFT  = 7;
    localparam int unsigned DAY_ODD    = 675;
    localparam int unsigned DAY_K      = 35;
    localparam logic [25:0] DAY_RECIP  = 26'(((64'd1 << DAY_K) + 64'(DAY_ODD) - 64'd1)
                                            / 64'(DAY_ODD));

    // Lower bound of the year count: days / 366
    localparam int unsigned LEAP_LEN   = 366;
    localparam int unsigned YEAR_K     = 25;
    localparam logic [16:0] YEAR_RECIP = 17'(((64'd1 << YEAR_K) + 64'(LEAP_LEN) - 64'd1)
                                            / 64'(LEAP_LEN));

    localparam int unsigned SECS_HOUR  = 3600;
    localparam int unsigned HOUR_K     = 29;
    localparam logic [17:0] HOUR_RECIP = 18'(((64'd1 << HOUR_K) + 64'(SECS_HOUR) - 64'd1)
                                            / 64'(SECS_HOUR));

    localparam int unsigned SECS_MIN   = 60;
    localparam int unsigned MIN_K      = 18;
    localparam logic [12:0] MIN_RECIP  = 13'(((64'd1 << MIN_K) + 64'(SECS_MIN) - 64'd1)
                                            / 64'(SECS_MIN));

    localparam int unsigned YEAR_LEN   = 365;
    localparam int unsigned BASE_OFS   = 1970 - 1900;
    localparam int unsigned LAST_YEAR  = 136;          // 2106 counted from 1970
    localparam int unsigned Y2101      = 2101 - 1970;  // first year after the 2100 skip
    localparam int unsigned MAX_DOY    = 365;

    // First day (counted from 1970-01-01) of the year 1970 + n
    function automatic t_days year_start(input logic [7:0] n);
        logic [16:0] base;
        logic [6:0]  leaps;
        base  = 17'(n) * 17'(YEAR_LEN);
        leaps = 7'((9'(n) + 9'd1) >> 2);
        if (32'(n) >= Y2101) begin
            leaps = leaps - 7'd1;
        end
        return t_days'(base + 17'(leaps));
    endfunction

endpackage

### src/esc_if.sv
// ============================================================================
// esc interfaces: valid/ready channels of the epoch seconds converter
// Input channel carries the seconds count, result channel the calendar fields.
// ============================================================================
interface esc_in_if import esc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_epoch epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface esc_out_if import esc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_year years_since_1900;
    t_doy  yday;
    t_hour hour;
    t_min  minute;
    t_sec  second;

    modport source (output valid, output years_since_1900, output yday,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input years_since_1900, input yday,
                    input hour, input minute, input second, output ready);
endinterface

### src/epoch_seconds_to_calendar.sv
// ============================================================================
// epoch_seconds_to_calendar: seconds since 1970 to year, day of year and time
// Six-stage pipeline of constant-reciprocal divides and a year-start lookup.
// ============================================================================
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC
// into the year minus 1900, the zero-based day of the year and the hour,
// minute and second of the day (Gregorian leap rule, so 2100 is common and
// 2000 is leap). A result passes through the registered stages A to F in
// order, and a new item may be transferred every cycle while the result is
// not held on o_res.ready; throughput is one item per cycle, set by the six
// registered stages.
// The whole pipeline stalls as one while a result waits on o_res.ready.
// No state is kept between items and reset only clears the valid bits.
module epoch_seconds_to_calendar import esc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    esc_in_if.sink    i_src,
    esc_out_if.source o_res
);

    // Pipeline advance: everything moves unless the result register is held
    logic w_adv;
    assign w_adv       = !o_res.valid || o_res.ready;
    assign i_src.ready = w_adv;

    // ---------------------------------------------------------------------
    // Stage A: days = secs / 86400, as (secs >> 7) / 675 by reciprocal.
    // The rounded-up reciprocal with k = 35 is exact for a 25-bit dividend.
    // ---------------------------------------------------------------------
    logic [24:0] w_a_x;
    logic [50:0] w_a_prod;
    logic        r_a_valid;
    logic [24:0] r_a_x,    n_a_x;
    logic [6:0]  r_a_low,  n_a_low;
    t_days       r_a_days, n_a_days;

    always_comb begin
        w_a_x    = i_src.epoch_seconds[31:DAY_SHIFT];
        w_a_prod = 51'(w_a_x) * 51'(DAY_RECIP);
        n_a_x    = w_a_x;
        n_a_low  = i_src.epoch_seconds[DAY_SHIFT-1:0];
        n_a_days = w_a_prod[50:DAY_K];
    end

    // ---------------------------------------------------------------------
    // Stage B: second of day from the odd remainder; lower bound of the
    // year count as days / 366 (exact reciprocal, k = 25).
    // ---------------------------------------------------------------------
    logic [25:0] w_b_back;
    logic [24:0] w_b_rem;
    logic [32:0] w_b_yprod;
    logic         r_b_valid;
    t_days        r_b_days, n_b_days;
    t_secs_of_day r_b_sod,  n_b_sod;
    logic [7:0]   r_b_nlo,  n_b_nlo;

    always_comb begin
        w_b_back  = 26'(r_a_days) * 26'(DAY_ODD);
        w_b_rem   = r_a_x - w_b_back[24:0];
        w_b_yprod = 33'(r_a_days) * 33'(YEAR_RECIP);
        n_b_days  = r_a_days;
        n_b_sod   = {w_b_rem[9:0], r_a_low};
        n_b_nlo   = w_b_yprod[32:YEAR_K];
    end

    // ---------------------------------------------------------------------
    // Stage C: the true year count is the bound or one more; pick it by
    // comparing against the start of the next year. Hour by reciprocal.
    // ---------------------------------------------------------------------
    logic [7:0]  w_c_nhi;
    t_days       w_c_start_lo, w_c_start_hi, w_c_doy;
    logic [34:0] w_c_hprod;
    logic         r_c_valid;
    logic [7:0]   r_c_n,    n_c_n;
    t_doy         r_c_doy,  n_c_doy;
    t_hour        r_c_hour, n_c_hour;
    t_secs_of_day r_c_sod,  n_c_sod;

    always_comb begin
        w_c_nhi      = r_b_nlo + 8'd1;
        w_c_start_lo = year_start(r_b_nlo);
        w_c_start_hi = year_start(w_c_nhi);
        if (r_b_days >= w_c_start_hi) begin
            n_c_n   = w_c_nhi;
            w_c_doy = r_b_days - w_c_start_hi;
        end else begin
            n_c_n   = r_b_nlo;
            w_c_doy = r_b_days - w_c_start_lo;
        end
        n_c_doy   = w_c_doy[8:0];
        w_c_hprod = 35'(r_b_sod) * 35'(HOUR_RECIP);
        n_c_hour  = w_c_hprod[HOUR_K+4:HOUR_K];
        n_c_sod   = r_b_sod;
    end

    // ---------------------------------------------------------------------
    // Stage D: seconds within the hour; year offset from 1900.
    // ---------------------------------------------------------------------
    logic [16:0] w_d_back;
    logic          r_d_valid;
    t_year         r_d_year, n_d_year;
    t_doy          r_d_doy,  n_d_doy;
    t_hour         r_d_hour, n_d_hour;
    t_secs_of_hour r_d_soh,  n_d_soh;

    always_comb begin
        w_d_back = 17'(r_c_hour) * 17'(SECS_HOUR);
        n_d_soh  = t_secs_of_hour'(r_c_sod - w_d_back);
        n_d_year = r_c_n + 8'(BASE_OFS);
        n_d_doy  = r_c_doy;
        n_d_hour = r_c_hour;
    end

    // ---------------------------------------------------------------------
    // Stage E: minute by reciprocal (k = 18, exact below 3600).
    // ---------------------------------------------------------------------
    logic [24:0] w_e_mprod;
    logic          r_e_valid;
    t_year         r_e_year, n_e_year;
    t_doy          r_e_doy,  n_e_doy;
    t_hour         r_e_hour, n_e_hour;
    t_min          r_e_min,  n_e_min;
    t_secs_of_hour r_e_soh,  n_e_soh;

    always_comb begin
        w_e_mprod = 25'(r_d_soh) * 25'(MIN_RECIP);
        n_e_min   = w_e_mprod[MIN_K+5:MIN_K];
        n_e_year  = r_d_year;
        n_e_doy   = r_d_doy;
        n_e_hour  = r_d_hour;
        n_e_soh   = r_d_soh;
    end

    // ---------------------------------------------------------------------
    // Stage F: second of minute; result register.
    // ---------------------------------------------------------------------
    logic [11:0] w_f_back;
    logic [11:0] w_f_sec;
    logic  r_f_valid;
    t_year r_f_year, n_f_year;
    t_doy  r_f_doy,  n_f_doy;
    t_hour r_f_hour, n_f_hour;
    t_min  r_f_min,  n_f_min;
    t_sec  r_f_sec,  n_f_sec;

    always_comb begin
        w_f_back = 12'(r_e_min) * 12'(SECS_MIN);
        w_f_sec  = r_e_soh - w_f_back;
        n_f_sec  = w_f_sec[5:0];
        n_f_year = r_e_year;
        n_f_doy  = r_e_doy;
        n_f_hour = r_e_hour;
        n_f_min  = r_e_min;
    end

    // Valid bits: cleared by reset, shifted on advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_src.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
            r_f_valid <= r_e_valid;
        end
    end

    // Payload: no reset, held while stalled
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_x    <= n_a_x;
            r_a_low  <= n_a_low;
            r_a_days <= n_a_days;
            r_b_days <= n_b_days;
            r_b_sod  <= n_b_sod;
            r_b_nlo  <= n_b_nlo;
            r_c_n    <= n_c_n;
            r_c_doy  <= n_c_doy;
            r_c_hour <= n_c_hour;
            r_c_sod  <= n_c_sod;
            r_d_year <= n_d_year;
            r_d_doy  <= n_d_doy;
            r_d_hour <= n_d_hour;
            r_d_soh  <= n_d_soh;
            r_e_year <= n_e_year;
            r_e_doy  <= n_e_doy;
            r_e_hour <= n_e_hour;
            r_e_min  <= n_e_min;
            r_e_soh  <= n_e_soh;
            r_f_year <= n_f_year;
            r_f_doy  <= n_f_doy;
            r_f_hour <= n_f_hour;
            r_f_min  <= n_f_min;
            r_f_sec  <= n_f_sec;
        end
    end

    assign o_res.valid            = r_f_valid;
    assign o_res.years_since_1900 = r_f_year;
    assign o_res.yday             = r_f_doy;
    assign o_res.hour             = r_f_hour;
    assign o_res.minute           = r_f_min;
    assign o_res.second           = r_f_sec;

`ifndef NO_ASSERTIONS
    // Year choice never runs past the last representable year
    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> (32'(r_c_n) <= LAST_YEAR))
        else $error("year count out of range");

    // Day of year of the chosen year stays at or below 365
    a_doy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> (32'(r_c_doy) <= MAX_DOY))
        else $error("day of year out of range");

    // Hour, minute and second stay in range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.hour < 5'd24 && o_res.minute < 6'd60
                         && o_res.second < 6'd60))
        else $error("time of day out of range");

    // A stalled result is neither dropped nor replaced
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(r_e_soh)
                                           && $stable(r_f_sec)))
        else $error("pipeline moved during stall");
`endif

endmodule
